[rtl/sumon_pkg.sv]
`timescale 1ns / 1ps
package sumon_pkg;

  // Event selector carried in s_tuser
  typedef enum logic [2:0] {
    FUNC_REFILL      = 3'd0,
    FUNC_VSYNC       = 3'd1,
    FUNC_MARK        = 3'd2,
    FUNC_RESTART     = 3'd3,
    FUNC_READ_BUCKET = 3'd4,
    FUNC_READ_LOG    = 3'd5,
    FUNC_CLEAR       = 3'd6
  } func_t;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 360;

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_LAG_THRESHOLD = 1'b0;

  // Frames skipped after clear before headroom is measured
  localparam logic [31:0] WARMUP_FRAMES = 32'd4;
  // Histogram bucket width is 128 us
  localparam int unsigned HIST_SHIFT = 7;
  // Since-time of a source that was never marked
  localparam logic [31:0] NEVER_SINCE = 32'hFFFF_FFFF;

  // Histogram memory control
  typedef struct packed {
    logic issue;   // item accepted: read the addressed bucket
    logic clear;   // accepted item is a clear
    logic commit;  // stage 1 item moves to the output register
    logic incr;    // stage 1 item bumps its bucket
  } hist_cmd_t;

  // Log memory control
  typedef struct packed {
    logic issue;   // item accepted: read the addressed slot
    logic append;  // accepted item writes a log entry
  } log_cmd_t;

endpackage

[rtl/sumon_cfg.sv]
`timescale 1ns / 1ps
module sumon_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sumon_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [31:0]                   lag_threshold
);
  import sumon_pkg::*;

  logic hit;
  logic wr;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_LAG_THRESHOLD);
  assign wr     = psel && penable && pwrite && pready;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      lag_threshold <= 32'd0;
    end else if (wr && hit) begin
      lag_threshold <= pwdata;
    end
  end

  // Return the addressed register
  assign prdata = hit ? lag_threshold : 32'd0;

endmodule

[rtl/sumon_hist.sv]
`timescale 1ns / 1ps
module sumon_hist #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sumon_pkg::hist_cmd_t cmd,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [31:0]          count
);
  import sumon_pkg::*;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic [ADDR_W-1:0] addr_q;
  logic [DEPTH-1:0]  valid;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [31:0]       fwd_data;
  logic              wr;
  logic [31:0]       count_inc;

  assign wr        = cmd.commit && cmd.incr;
  assign count_inc = count + 32'd1;

  // Pick the current count: same-edge write, then memory, then cleared value
  always_comb begin
    if (fwd_valid && (fwd_addr == addr_q)) begin
      count = fwd_data;
    end else if (valid[addr_q]) begin
      count = rdata;
    end else begin
      count = 32'd0;
    end
  end

  // Read on accept, write back on commit
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
    if (wr) begin
      mem[addr_q] <= count_inc;
      fwd_addr    <= addr_q;
      fwd_data    <= count_inc;
    end
  end

  // Track written buckets; a clear wins over a same-edge write back
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      fwd_valid <= 1'b0;
    end else if (cmd.issue && cmd.clear) begin
      valid     <= '0;
      fwd_valid <= 1'b0;
    end else if (wr) begin
      valid[addr_q] <= 1'b1;
      fwd_valid     <= 1'b1;
    end
  end

endmodule

[rtl/sumon_log.sv]
`timescale 1ns / 1ps
module sumon_log #(
  parameter int DEPTH   = 32,
  parameter int SLOT_W  = 5,
  parameter int SOURCES = 4
) (
  input  logic                   clk,
  input  sumon_pkg::log_cmd_t    cmd,
  input  logic [SLOT_W-1:0]      wr_slot,
  input  logic [31:0]            wr_frame,
  input  logic [31:0]            wr_time,
  input  logic [31:0]            wr_margin,
  input  logic [SOURCES*32-1:0]  wr_since,
  input  logic [SLOT_W-1:0]      rd_slot,
  output logic [31:0]            rd_frame,
  output logic [31:0]            rd_time,
  output logic [31:0]            rd_margin,
  output logic [SOURCES*32-1:0]  rd_since
);
  import sumon_pkg::*;

  logic [31:0]           frame_mem  [DEPTH];
  logic [31:0]           time_mem   [DEPTH];
  logic [31:0]           margin_mem [DEPTH];
  logic [SOURCES*32-1:0] since_mem  [DEPTH];

  // Write one entry per append, one since-time row for all sources
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      frame_mem[wr_slot]  <= wr_frame;
      time_mem[wr_slot]   <= wr_time;
      margin_mem[wr_slot] <= wr_margin;
      since_mem[wr_slot]  <= wr_since;
    end
  end

  // Read the selected entry on accept
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_frame  <= frame_mem[rd_slot];
      rd_time   <= time_mem[rd_slot];
      rd_margin <= margin_mem[rd_slot];
      rd_since  <= since_mem[rd_slot];
    end
  end

endmodule

[rtl/scanout_underrun_monitor_core.sv]
`timescale 1ns / 1ps
// An accepted item is held in stage 1, then moves to the output register when that is free
// or being taken. Throughput: one item per cycle unless m_tready stalls; the histogram
// read-modify-write keeps that pace by forwarding a write back on the same edge as the next read.
// Reset (synchronous, rst high) clears counters, margins, histogram valid bits, log
// pointers, activity times and the threshold; log memories hold data until rewritten.
module scanout_underrun_monitor_core #(
  parameter int MARGIN_BUCKETS   = 16,
  parameter int ACTIVITY_SOURCES = 4,
  parameter int LOG_DEPTH        = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_us, event_value, read_index, act_index (from bit 0 up), zero pad
  input  logic [sumon_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // frame_count, refill_count, slip_count, max_drift, margin_last_us,
  // margin_min_us, margin_max_us, log_held, read_data, entry_frame,
  // entry_time_us, entry_margin_us (from bit 0 up), zero pad
  output logic [sumon_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sumon_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import sumon_pkg::*;

  localparam int BW    = (MARGIN_BUCKETS > 1) ? $clog2(MARGIN_BUCKETS) : 1;
  localparam int AW    = (ACTIVITY_SOURCES > 1) ? $clog2(ACTIVITY_SOURCES) : 1;
  localparam int SW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FW    = $clog2(LOG_DEPTH + 1);
  localparam int SUMW  = ((SW > 4) ? SW : 4) + 2;
  localparam int ROW_W = ACTIVITY_SOURCES * 32;

  // Input fields
  func_t       in_func;
  logic [31:0] in_now;
  logic [31:0] in_value;
  logic [4:0]  in_ridx;
  logic [1:0]  in_aidx;

  assign in_func  = func_t'(s_tuser);
  assign in_now   = s_tdata[31:0];
  assign in_value = s_tdata[63:32];
  assign in_ridx  = s_tdata[68:64];
  assign in_aidx  = s_tdata[70:69];

  // Handshake
  logic s1_valid;
  logic out_valid;
  logic adv1;
  logic accept;

  assign adv1     = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || adv1;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  // Configuration
  logic [31:0] lag_threshold;

  sumon_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .lag_threshold (lag_threshold)
  );

  // Scalar state
  logic [31:0]   frames;
  logic [31:0]   refills;
  logic [31:0]   slips;
  logic [31:0]   peak_drift;
  logic [31:0]   refills_at_vsync;
  logic [31:0]   last_refill;
  logic [31:0]   head_last;
  logic [31:0]   head_min;
  logic [31:0]   head_max;
  logic [SW-1:0] write_slot;
  logic [FW-1:0] log_fill;
  logic [31:0]   act_time [ACTIVITY_SOURCES];

  // Stage 0 event arithmetic
  logic [31:0]     frames_inc;
  logic [31:0]     drift;
  logic [31:0]     margin;
  logic [31:0]     margin_shift;
  logic            measure;
  logic            done;
  logic            vsync_log;
  logic            append;
  logic            hist_incr;
  logic [BW-1:0]   vs_bucket;
  logic [7:0]      ridx_ext;
  logic [BW-1:0]   rd_bucket;
  logic            bucket_ok;
  logic [3:0]      aidx_ext;
  logic [AW-1:0]   asel;
  logic            aidx_ok;
  logic            log_ok;
  logic [SUMW-1:0] rd_sum;
  logic [SW-1:0]   rd_slot;
  logic [SW-1:0]   slot_inc;
  logic [31:0]     app_frame;
  logic [31:0]     app_margin;
  logic [ROW_W-1:0] since_row;

  assign frames_inc   = frames + 32'd1;
  assign drift        = frames_inc - refills;
  assign margin       = in_now - last_refill;
  assign margin_shift = margin >> HIST_SHIFT;
  assign measure      = frames_inc > WARMUP_FRAMES;
  assign done         = refills != refills_at_vsync;
  assign vsync_log    = measure &&
                        (!done || ((lag_threshold != 32'd0) && (margin < lag_threshold)));
  assign append       = ((in_func == FUNC_VSYNC) && vsync_log) || (in_func == FUNC_RESTART);
  assign hist_incr    = (in_func == FUNC_VSYNC) && measure && done;
  assign vs_bucket    = (margin_shift >= 32'(MARGIN_BUCKETS)) ?
                        BW'(MARGIN_BUCKETS - 1) : margin_shift[BW-1:0];
  assign ridx_ext     = 8'(in_ridx);
  assign rd_bucket    = ridx_ext[BW-1:0];
  assign bucket_ok    = 32'(in_ridx) < 32'(MARGIN_BUCKETS);
  assign aidx_ext     = 4'(in_aidx);
  assign asel         = aidx_ext[AW-1:0];
  assign aidx_ok      = 32'(in_aidx) < 32'(ACTIVITY_SOURCES);
  assign log_ok       = 32'(in_ridx) < 32'(log_fill);
  assign app_frame    = (in_func == FUNC_VSYNC) ? frames_inc : frames;
  assign app_margin   = (in_func == FUNC_RESTART) ? in_value : (done ? margin : 32'd0);
  assign slot_inc     = (write_slot == SW'(LOG_DEPTH - 1)) ? '0 : write_slot + SW'(1);

  // Oldest-first position to ring slot; the sum stays below twice the depth for a position below the fill
  assign rd_sum  = SUMW'(write_slot) + SUMW'(LOG_DEPTH) - SUMW'(log_fill) + SUMW'(in_ridx);
  assign rd_slot = (rd_sum >= SUMW'(LOG_DEPTH)) ? SW'(rd_sum - SUMW'(LOG_DEPTH)) : SW'(rd_sum);

  // Time since each source was marked
  always_comb begin
    for (int s = 0; s < ACTIVITY_SOURCES; s++) begin
      since_row[s*32 +: 32] = (act_time[s] == 32'd0) ? NEVER_SINCE : in_now - act_time[s];
    end
  end

  // Update scalar state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      frames           <= 32'd0;
      refills          <= 32'd0;
      slips            <= 32'd0;
      peak_drift       <= 32'd0;
      refills_at_vsync <= 32'd0;
      last_refill      <= 32'd0;
      head_last        <= 32'd0;
      head_min         <= NEVER_SINCE;
      head_max         <= 32'd0;
      write_slot       <= '0;
      log_fill         <= '0;
      for (int s = 0; s < ACTIVITY_SOURCES; s++) begin
        act_time[s] <= 32'd0;
      end
    end else if (accept) begin
      case (in_func)
        FUNC_REFILL: begin
          refills     <= refills + 32'd1;
          last_refill <= in_now;
        end
        FUNC_VSYNC: begin
          frames           <= frames_inc;
          refills_at_vsync <= refills;
          if (drift > peak_drift) begin
            peak_drift <= drift;
          end
          if (measure) begin
            if (done) begin
              head_last <= margin;
              if (margin < head_min) begin
                head_min <= margin;
              end
              if (margin > head_max) begin
                head_max <= margin;
              end
            end else begin
              slips <= slips + 32'd1;
            end
          end
        end
        FUNC_MARK: begin
          if (aidx_ok) begin
            act_time[asel] <= in_now;
          end
        end
        FUNC_CLEAR: begin
          frames           <= 32'd0;
          refills          <= 32'd0;
          slips            <= 32'd0;
          peak_drift       <= 32'd0;
          refills_at_vsync <= 32'd0;
          last_refill      <= 32'd0;
          head_last        <= 32'd0;
          head_min         <= NEVER_SINCE;
          head_max         <= 32'd0;
          write_slot       <= '0;
          log_fill         <= '0;
        end
        default: begin
        end
      endcase
      // Advance the log ring
      if (append) begin
        write_slot <= slot_inc;
        if (log_fill != FW'(LOG_DEPTH)) begin
          log_fill <= log_fill + FW'(1);
        end
      end
    end
  end

  // Histogram memory
  hist_cmd_t   hist_cmd;
  logic [31:0] hist_count;
  logic        s1_incr;

  assign hist_cmd.issue  = accept;
  assign hist_cmd.clear  = accept && (in_func == FUNC_CLEAR);
  assign hist_cmd.commit = adv1;
  assign hist_cmd.incr   = s1_incr;

  sumon_hist #(
    .DEPTH  (MARGIN_BUCKETS),
    .ADDR_W (BW)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .cmd     (hist_cmd),
    .rd_addr ((in_func == FUNC_VSYNC) ? vs_bucket : rd_bucket),
    .count   (hist_count)
  );

  // Log memories
  log_cmd_t         log_cmd;
  logic [31:0]      lg_frame;
  logic [31:0]      lg_time;
  logic [31:0]      lg_margin;
  logic [ROW_W-1:0] lg_since;

  assign log_cmd.issue  = accept;
  assign log_cmd.append = accept && append;

  sumon_log #(
    .DEPTH   (LOG_DEPTH),
    .SLOT_W  (SW),
    .SOURCES (ACTIVITY_SOURCES)
  ) u_log (
    .clk       (clk),
    .cmd       (log_cmd),
    .wr_slot   (write_slot),
    .wr_frame  (app_frame),
    .wr_time   (in_now),
    .wr_margin (app_margin),
    .wr_since  (since_row),
    .rd_slot   (rd_slot),
    .rd_frame  (lg_frame),
    .rd_time   (lg_time),
    .rd_margin (lg_margin),
    .rd_since  (lg_since)
  );

  // Stage 1 item registers
  func_t         s1_func;
  logic          s1_bucket_ok;
  logic          s1_log_ok;
  logic          s1_aidx_ok;
  logic [AW-1:0] s1_asel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func      <= in_func;
      s1_incr      <= hist_incr;
      s1_bucket_ok <= bucket_ok;
      s1_log_ok    <= log_ok;
      s1_aidx_ok   <= aidx_ok;
      s1_asel      <= asel;
    end
  end

  // Select read fields for the result
  logic [31:0] rd_data;
  logic [31:0] e_frame;
  logic [31:0] e_time;
  logic [31:0] e_margin;
  logic [31:0] min_out;
  logic [31:0] fill_ext;

  always_comb begin
    rd_data  = 32'd0;
    e_frame  = 32'd0;
    e_time   = 32'd0;
    e_margin = 32'd0;
    case (s1_func)
      FUNC_READ_BUCKET: begin
        if (s1_bucket_ok) begin
          rd_data = hist_count;
        end
      end
      FUNC_READ_LOG: begin
        if (s1_log_ok) begin
          e_frame  = lg_frame;
          e_time   = lg_time;
          e_margin = lg_margin;
          if (s1_aidx_ok) begin
            rd_data = lg_since[s1_asel*32 +: 32];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign min_out  = (head_min == NEVER_SINCE) ? 32'd0 : head_min;
  assign fill_ext = 32'(log_fill);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv1) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      m_tdata <= {2'b00, e_margin, e_time, e_frame, rd_data, fill_ext[5:0],
                  head_max, min_out, head_last, peak_drift, slips, refills, frames};
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import sumon_pkg::*;

  localparam int BUCKETS   = 16;
  localparam int SOURCES   = 4;
  localparam int LOG_SLOTS = 32;
  localparam int MAX_IDLE  = 18;

  // Selector value that the block has no event for
  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam logic [PADDR_W-1:0] THRESH_ADDR = {REG_LAG_THRESHOLD, 2'b00};

  // Input item payload, first field in the low bits
  typedef struct packed {
    logic [1:0]  act_index;
    logic [4:0]  read_index;
    logic [31:0] event_value;
    logic [31:0] now_us;
  } event_data_t;

  typedef struct packed {
    logic [2:0]  func;
    event_data_t d;
  } monitor_event_t;

  // Result item, frame_count in the low bits
  typedef struct packed {
    logic [31:0] entry_margin_us;
    logic [31:0] entry_time_us;
    logic [31:0] entry_frame;
    logic [31:0] read_data;
    logic [5:0]  log_held;
    logic [31:0] margin_max_us;
    logic [31:0] margin_min_us;
    logic [31:0] margin_last_us;
    logic [31:0] max_drift;
    logic [31:0] slip_count;
    logic [31:0] refill_count;
    logic [31:0] frame_count;
  } status_t;

  // Directed row; zero_known rows must return an all-zero status
  typedef struct packed {
    bit             zero_known;
    monitor_event_t ev;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic [2:0]              s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  scanout_underrun_monitor_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the monitor state
  logic [31:0] hm_threshold;
  logic [31:0] hm_frames, hm_refills, hm_slips, hm_peak_drift;
  logic [31:0] hm_refills_at_vsync, hm_refill_time;
  logic [31:0] hm_head_last, hm_head_min, hm_head_max;
  logic [31:0] hm_hist [BUCKETS];
  logic [31:0] hm_mark [SOURCES];
  logic [31:0] lg_frame [LOG_SLOTS];
  logic [31:0] lg_time [LOG_SLOTS];
  logic [31:0] lg_margin [LOG_SLOTS];
  logic [31:0] lg_since [LOG_SLOTS][SOURCES];
  int          lg_wr, lg_fill;

  status_t     status_q[$];
  dir_row_t    dir_tab[$];
  logic [31:0] stamp_us;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;

  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_measured = 0;
  int unsigned n_slipped = 0;
  int unsigned n_logged = 0;
  int unsigned n_clears = 0;
  int unsigned n_settings = 0;

  function automatic void clear_stats();
    hm_frames = '0;
    hm_refills = '0;
    hm_slips = '0;
    hm_peak_drift = '0;
    hm_refills_at_vsync = '0;
    hm_refill_time = '0;
    hm_head_last = '0;
    hm_head_min = '1;
    hm_head_max = '0;
    for (int i = 0; i < BUCKETS; i++) hm_hist[i] = '0;
    lg_wr = 0;
    lg_fill = 0;
  endfunction

  function automatic void log_append(logic [31:0] now, logic [31:0] margin);
    lg_frame[lg_wr] = hm_frames;
    lg_time[lg_wr] = now;
    lg_margin[lg_wr] = margin;
    for (int s = 0; s < SOURCES; s++)
      lg_since[lg_wr][s] = (hm_mark[s] == 0) ? NEVER_SINCE : now - hm_mark[s];
    lg_wr = (lg_wr + 1) % LOG_SLOTS;
    if (lg_fill < LOG_SLOTS) lg_fill++;
    n_logged++;
  endfunction

  function automatic void vsync_update(logic [31:0] now);
    logic [31:0] drift, done, margin, bucket;
    hm_frames = hm_frames + 32'd1;
    drift = hm_frames - hm_refills;
    if (drift > hm_peak_drift) hm_peak_drift = drift;
    done = hm_refills - hm_refills_at_vsync;
    hm_refills_at_vsync = hm_refills;
    if (hm_frames <= WARMUP_FRAMES) return;
    if (done != 0) begin
      margin = now - hm_refill_time;
      bucket = margin >> HIST_SHIFT;
      hm_head_last = margin;
      if (margin < hm_head_min) hm_head_min = margin;
      if (margin > hm_head_max) hm_head_max = margin;
      if (bucket >= BUCKETS) bucket = BUCKETS - 1;
      hm_hist[bucket] = hm_hist[bucket] + 32'd1;
      n_measured++;
      if (hm_threshold != 0 && margin < hm_threshold) log_append(now, margin);
    end else begin
      hm_slips = hm_slips + 32'd1;
      n_slipped++;
      log_append(now, 32'd0);
    end
  endfunction

  // Apply one accepted item to the shadow state and return its status
  function automatic status_t predict_status(monitor_event_t ev);
    status_t r;
    int      slot;
    r = '0;
    case (ev.func)
      FUNC_REFILL: begin
        hm_refills = hm_refills + 32'd1;
        hm_refill_time = ev.d.now_us;
      end
      FUNC_VSYNC: vsync_update(ev.d.now_us);
      FUNC_MARK: hm_mark[ev.d.act_index] = ev.d.now_us;
      FUNC_RESTART: log_append(ev.d.now_us, ev.d.event_value);
      FUNC_READ_BUCKET: begin
        if (ev.d.read_index < BUCKETS) r.read_data = hm_hist[ev.d.read_index];
      end
      FUNC_READ_LOG: begin
        if (ev.d.read_index < lg_fill) begin
          slot = (lg_wr + LOG_SLOTS - lg_fill + ev.d.read_index) % LOG_SLOTS;
          r.entry_frame = lg_frame[slot];
          r.entry_time_us = lg_time[slot];
          r.entry_margin_us = lg_margin[slot];
          r.read_data = lg_since[slot][ev.d.act_index];
        end
      end
      FUNC_CLEAR: begin
        clear_stats();
        n_clears++;
      end
      default: ;
    endcase
    r.frame_count = hm_frames;
    r.refill_count = hm_refills;
    r.slip_count = hm_slips;
    r.max_drift = hm_peak_drift;
    r.margin_last_us = hm_head_last;
    r.margin_min_us = (hm_head_min == '1) ? 32'd0 : hm_head_min;
    r.margin_max_us = hm_head_max;
    r.log_held = lg_fill[5:0];
    return r;
  endfunction

  function automatic monitor_event_t mk(logic [2:0] f, logic [31:0] now, logic [31:0] val,
                                        logic [4:0] ridx, logic [1:0] aidx);
    monitor_event_t ev;
    ev.func = f;
    ev.d.now_us = now;
    ev.d.event_value = val;
    ev.d.read_index = ridx;
    ev.d.act_index = aidx;
    return ev;
  endfunction

  function automatic dir_row_t row(bit known, logic [2:0] f, logic [31:0] now,
                                   logic [31:0] val, logic [4:0] ridx, logic [1:0] aidx);
    dir_row_t r;
    r.zero_known = known;
    r.ev = mk(f, now, val, ridx, aidx);
    return r;
  endfunction

  function automatic int draw_idle(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void check_status(status_t got);
    status_t want;
    if (status_q.size() == 0) begin
      $display("%0t: result with no item outstanding, expected none, actual %h", $time, got);
      n_errors++;
      return;
    end
    want = status_q.pop_front();
    n_checked++;
    field_check("frame_count", want.frame_count, got.frame_count);
    field_check("refill_count", want.refill_count, got.refill_count);
    field_check("slip_count", want.slip_count, got.slip_count);
    field_check("max_drift", want.max_drift, got.max_drift);
    field_check("margin_last_us", want.margin_last_us, got.margin_last_us);
    field_check("margin_min_us", want.margin_min_us, got.margin_min_us);
    field_check("margin_max_us", want.margin_max_us, got.margin_max_us);
    field_check("log_held", 32'(want.log_held), 32'(got.log_held));
    field_check("read_data", want.read_data, got.read_data);
    field_check("entry_frame", want.entry_frame, got.entry_frame);
    field_check("entry_time_us", want.entry_time_us, got.entry_time_us);
    field_check("entry_margin_us", want.entry_margin_us, got.entry_margin_us);
  endfunction

  // Offer one item after a drawn gap, then record its expected status on acceptance
  task automatic send_event(input monitor_event_t ev, input bit zero_known);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    status_t               res;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = draw_idle(src_quiet);
    word = '0;
    word[$bits(event_data_t)-1:0] = ev.d;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ev.func;
    s_tdata <= word;
    do @(posedge clk); while (s_tready !== 1'b1);
    res = predict_status(ev);
    status_q.push_back(zero_known ? status_t'('0) : res);
    n_items++;
  endtask

  // Hold off input until every result is back, then let the pipeline settle
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (status_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write the threshold, then read it back
  task automatic write_threshold(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESH_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    hm_threshold = value;
    n_settings++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== value) begin
      $display("%0t: lag_threshold_us readback mismatch, expected %h, actual %h",
               $time, value, prdata);
      n_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed frames with random headroom, plus reads, restarts and noise
  task automatic run_traffic(input int quota);
    int         sent, pick, k, refill_n;
    logic [2:0] f;
    sent = 0;
    stamp_us = $urandom;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 3) == 0) begin
          stamp_us += $urandom_range(1, 200);
          send_event(mk(FUNC_MARK, stamp_us, $urandom, 5'($urandom_range(0, 31)),
                        2'($urandom_range(0, 3))), 1'b0);
          sent++;
        end
        refill_n = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 2);
        for (k = 0; k < refill_n; k++) begin
          stamp_us += $urandom_range(0, 400);
          send_event(mk(FUNC_REFILL, stamp_us, $urandom, 5'($urandom_range(0, 31)),
                        2'($urandom_range(0, 3))), 1'b0);
          sent++;
        end
        case ($urandom_range(0, 9))
          0: stamp_us += $urandom_range(0, 127);
          1: stamp_us += $urandom;
          default: stamp_us += $urandom_range(0, 2200);
        endcase
        send_event(mk(FUNC_VSYNC, stamp_us, $urandom, 5'($urandom_range(0, 31)),
                      2'($urandom_range(0, 3))), 1'b0);
        sent++;
      end else if (pick < 72) begin
        send_event(mk(FUNC_READ_BUCKET, $urandom, $urandom, 5'($urandom_range(0, 31)),
                      2'($urandom_range(0, 3))), 1'b0);
        sent++;
      end else if (pick < 80) begin
        send_event(mk(FUNC_READ_LOG, $urandom, $urandom, 5'($urandom_range(0, 31)),
                      2'($urandom_range(0, 3))), 1'b0);
        sent++;
      end else if (pick < 85) begin
        stamp_us += $urandom_range(0, 300);
        send_event(mk(FUNC_RESTART, stamp_us, $urandom, 5'($urandom_range(0, 31)),
                      2'($urandom_range(0, 3))), 1'b0);
        sent++;
      end else if (pick < 86) begin
        send_event(mk(FUNC_CLEAR, $urandom, $urandom, 5'($urandom_range(0, 31)),
                      2'($urandom_range(0, 3))), 1'b0);
        sent++;
      end else begin
        // noise: any selector, all fields random; keep clears rare
        f = 3'($urandom_range(0, 7));
        if (f == FUNC_CLEAR && $urandom_range(0, 3) != 0) f = FUNC_UNUSED;
        send_event(mk(f, $urandom, $urandom, 5'($urandom_range(0, 31)),
                      2'($urandom_range(0, 3))), 1'b0);
        if (f != FUNC_UNUSED) sent++;
      end
    end
  endtask

  // Result side: stall a drawn number of cycles, then take one item
  initial begin
    int stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
      stall = draw_idle(sink_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      check_status(status_t'(m_tdata[$bits(status_t)-1:0]));
    end
  end

  initial begin
    logic [31:0] settings [$];
    hm_threshold = '0;
    for (int s = 0; s < SOURCES; s++) hm_mark[s] = '0;
    clear_stats();

    // after reset, extremes, warmup, bucket and log corner cases, clear
    dir_tab.push_back(row(1'b1, FUNC_READ_BUCKET, 32'd0, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b1, FUNC_READ_LOG, 32'd0, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b1, FUNC_UNUSED, '1, '1, 5'd31, 2'd3));
    dir_tab.push_back(row(1'b1, FUNC_READ_BUCKET, '1, '1, 5'd31, 2'd3));
    dir_tab.push_back(row(1'b0, FUNC_MARK, 32'd0, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_MARK, 32'd1000, 32'd0, 5'd0, 2'd1));
    dir_tab.push_back(row(1'b0, FUNC_MARK, '1, 32'd0, 5'd0, 2'd3));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd2000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd3000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd4000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd5000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_REFILL, 32'd5100, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd5100, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_REFILL, 32'd6000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd9000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'd10000, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_RESTART, '1, '1, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_READ_BUCKET, 32'd0, 32'd0, 5'd15, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_READ_BUCKET, 32'd0, 32'd0, 5'd16, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_READ_LOG, 32'd0, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_READ_LOG, 32'd0, 32'd0, 5'd3, 2'd3));
    dir_tab.push_back(row(1'b0, FUNC_READ_LOG, 32'd0, 32'd0, 5'd31, 2'd2));
    dir_tab.push_back(row(1'b0, FUNC_REFILL, 32'hFFFF_FFF0, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b0, FUNC_VSYNC, 32'h0000_0010, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b1, FUNC_CLEAR, 32'd0, 32'd0, 5'd0, 2'd0));
    dir_tab.push_back(row(1'b1, FUNC_READ_LOG, 32'd0, 32'd0, 5'd0, 2'd0));

    settings.push_back(32'd0);
    settings.push_back(32'hFFFF_FFFF);
    settings.push_back(32'd1);
    settings.push_back(32'd700);
    settings.push_back($urandom_range(128, 2200));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_threshold(32'd4000);
    foreach (dir_tab[i]) send_event(dir_tab[i].ev, dir_tab[i].zero_known);
    drain();

    foreach (settings[i]) begin
      write_threshold(settings[i]);
      run_traffic(180);
      drain();
    end

    if (status_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, status_q.size());
      n_errors += status_q.size();
    end
    $display("Ran %0d items under %0d threshold settings, %0d results checked.",
             n_items, n_settings, n_checked);
    $display("Headroom measured %0d times, %0d slips, %0d log entries, %0d clears.",
             n_measured, n_slipped, n_logged, n_clears);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", status_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/sumon_pkg.sv
rtl/sumon_cfg.sv
rtl/sumon_hist.sv
rtl/sumon_log.sv
rtl/scanout_underrun_monitor_core.sv
tb/tb_top.sv
